### src/rpa_pkg.sv
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared types, widths, constants and GF(2^8) helpers for the RAID P/Q/R
// parity accumulator.
// ----------------------------------------------------------------------------
package rpa_pkg;

  // Field widths
  localparam int IdxW  = 9;
  localparam int DataW = 64;
  localparam int CntW  = 2;

  // Default column depth in 64-bit words
  localparam int ColumnWordsDef = 512;

  // Per-byte field constants, polynomial 0x11d
  localparam logic [7:0] BytePoly = 8'h1d;
  localparam int         NumBytes = DataW / 8;

  // Parity count register codes
  typedef enum logic [CntW-1:0] {
    PC_NONE = 2'd0,
    PC_P    = 2'd1,
    PC_PQ   = 2'd2,
    PC_PQR  = 2'd3
  } rpa_pcount_e;

  localparam rpa_pcount_e ParityCountRst = PC_PQR;

  // The three parity words of one entry
  typedef struct packed {
    logic [DataW-1:0] p;
    logic [DataW-1:0] q;
    logic [DataW-1:0] r;
  } rpa_words_t;

  // Control handed to the update logic
  typedef struct packed {
    logic        first_column;
    logic        in_range;
    rpa_pcount_e count;
  } rpa_upd_ctrl_t;

  // Multiply each byte by 2 in GF(2^8)
  function automatic logic [DataW-1:0] gf_times2(input logic [DataW-1:0] v);
    logic [DataW-1:0] res;
    logic [7:0]       b;
    res = '0;
    for (int k = 0; k < NumBytes; k++) begin
      b = v[8*k +: 8];
      res[8*k +: 8] = {b[6:0], 1'b0} ^ (b[7] ? BytePoly : 8'h00);
    end
    return res;
  endfunction

endpackage

### src/rpa_if.sv
// ----------------------------------------------------------------------------
// rpa_if
// Valid/ready stream interfaces for the parity accumulator: the data word
// request channel and the parity response channel.
// ----------------------------------------------------------------------------
interface rpa_in_if;
  logic                      valid;
  logic                      ready;
  logic [rpa_pkg::IdxW-1:0]  word_index;
  logic [rpa_pkg::DataW-1:0] data_word;
  logic                      first_column;

  modport source (output valid, word_index, data_word, first_column, input ready);
  modport sink   (input valid, word_index, data_word, first_column, output ready);
endinterface

interface rpa_out_if;
  logic                      valid;
  logic                      ready;
  logic [rpa_pkg::IdxW-1:0]  out_index;
  logic [rpa_pkg::DataW-1:0] parity_p;
  logic [rpa_pkg::DataW-1:0] parity_q;
  logic [rpa_pkg::DataW-1:0] parity_r;

  modport source (output valid, out_index, parity_p, parity_q, parity_r, input ready);
  modport sink   (input valid, out_index, parity_p, parity_q, parity_r, output ready);
endinterface

### src/raid_pqr_parity_accumulate_top.sv
// ----------------------------------------------------------------------------
// raid_pqr_parity_accumulate_top
// RAID P/Q/R parity accumulator over GF(2^8), polynomial 0x11d. Each request
// updates the parity entry at its word index (if inside the column) and returns the new words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-----------------------------------------
//  req_i   | in  | valid/ready   | word_index, data_word, first_column
//  rsp_o   | out | valid/ready   | out_index, parity_p, parity_q, parity_r
//  cfg     | in  | cfg_we_i      | cfg_wdata_i = parity_count
//
//  One request per cycle sustained while the response side does not stall;
//  the request and the synchronous parity memory read are registered in the
//  update stage, and the update is registered into the response register.
//  A write in the same cycle as the read of the same entry is forwarded.
//  No clearing pass after reset; requests are taken right away.
//  A stalled response holds the update stage and then the request side.
// ----------------------------------------------------------------------------
module raid_pqr_parity_accumulate_top #(
  parameter int COLUMN_WORDS = rpa_pkg::ColumnWordsDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [rpa_pkg::CntW-1:0] cfg_wdata_i,
  rpa_in_if.sink                   req_i,
  rpa_out_if.source                rsp_o
);

  localparam int AddrW = (COLUMN_WORDS > 1) ? $clog2(COLUMN_WORDS) : 1;
  localparam int IdxW  = rpa_pkg::IdxW;
  localparam int DataW = rpa_pkg::DataW;

  // Configuration
  rpa_pkg::rpa_pcount_e parity_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parity_count_q <= rpa_pkg::ParityCountRst;
    end else if (cfg_we_i) begin
      parity_count_q <= rpa_pkg::rpa_pcount_e'(cfg_wdata_i);
    end
  end

  // Handshake and address of the incoming request
  logic                  req_acc;
  logic                  s1_adv;
  logic [AddrW+IdxW-1:0] req_addr_wide;
  logic [AddrW-1:0]      req_addr;
  logic [31:0]           req_idx_ext;
  logic                  req_in_range;

  assign req_addr_wide = {{AddrW{1'b0}}, req_i.word_index};
  assign req_addr      = req_addr_wide[AddrW-1:0];
  assign req_idx_ext   = {{(32-IdxW){1'b0}}, req_i.word_index};
  assign req_in_range  = req_idx_ext < 32'(COLUMN_WORDS);

  // Update stage registers
  logic             s1_v_q;
  logic [IdxW-1:0]  s1_idx_q;
  logic [AddrW-1:0] s1_addr_q;
  logic [DataW-1:0] s1_data_q;
  logic             s1_first_q;
  logic             s1_inr_q;

  // Response registers
  logic                rsp_v_q;
  logic [IdxW-1:0]     rsp_idx_q;
  rpa_pkg::rpa_words_t rsp_words_q;

  assign s1_adv      = s1_v_q && (!rsp_v_q || rsp_o.ready);
  assign req_i.ready = !s1_v_q || s1_adv;
  assign req_acc     = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_v_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_idx_q   <= req_i.word_index;
      s1_addr_q  <= req_addr;
      s1_data_q  <= req_i.data_word;
      s1_first_q <= req_i.first_column;
      s1_inr_q   <= req_in_range;
    end
  end

  // Parity memory: P, Q, R side by side, registered read
  rpa_pkg::rpa_words_t mem [COLUMN_WORDS];
  rpa_pkg::rpa_words_t rdata_q;
  rpa_pkg::rpa_words_t store_w;
  rpa_pkg::rpa_words_t result_w;
  logic                mem_we;

  assign mem_we = s1_adv && s1_inr_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[s1_addr_q] <= store_w;
    end
    if (req_acc) begin
      rdata_q <= mem[req_addr];
    end
  end

  // Last write, forwarded when it raced the read of the same entry
  logic                wr_v_q;
  logic [AddrW-1:0]    wr_addr_q;
  rpa_pkg::rpa_words_t wr_words_q;
  rpa_pkg::rpa_words_t stored_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_v_q <= 1'b0;
    end else if (mem_we) begin
      wr_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      wr_addr_q  <= s1_addr_q;
      wr_words_q <= store_w;
    end
  end

  assign stored_w = (wr_v_q && (wr_addr_q == s1_addr_q)) ? wr_words_q : rdata_q;

  // Read-modify-write datapath
  rpa_pkg::rpa_upd_ctrl_t upd_ctrl;

  assign upd_ctrl.first_column = s1_first_q;
  assign upd_ctrl.in_range     = s1_inr_q;
  assign upd_ctrl.count        = parity_count_q;

  rpa_update u_update (
    .ctrl_i   (upd_ctrl),
    .data_i   (s1_data_q),
    .stored_i (stored_w),
    .store_o  (store_w),
    .result_o (result_w)
  );

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_v_q <= 1'b0;
    end else if (s1_adv) begin
      rsp_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      rsp_idx_q   <= s1_idx_q;
      rsp_words_q <= result_w;
    end
  end

  assign rsp_o.valid     = rsp_v_q;
  assign rsp_o.out_index = rsp_idx_q;
  assign rsp_o.parity_p  = rsp_words_q.p;
  assign rsp_o.parity_q  = rsp_words_q.q;
  assign rsp_o.parity_r  = rsp_words_q.r;

  // Assertions
  a_hold_blocks_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !s1_adv) |-> !req_i.ready)
    else $error("request taken while update stage is held");

  a_adv_fills_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> rsp_v_q)
    else $error("update did not reach response register");

  a_fwd_tracks_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (wr_v_q && wr_addr_q == $past(s1_addr_q)))
    else $error("forwarding register missed a write");

  a_rsp_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (rsp_o.out_index == $past(s1_idx_q)))
    else $error("response index differs from updated entry");

endmodule

### src/rpa_update.sv
// ----------------------------------------------------------------------------
// rpa_update
// Read-modify-write datapath: folds one data word into the stored P, Q and
// R words and forms both the write-back entry and the returned words.
// ----------------------------------------------------------------------------
module rpa_update (
  input  rpa_pkg::rpa_upd_ctrl_t      ctrl_i,
  input  logic [rpa_pkg::DataW-1:0]   data_i,
  input  rpa_pkg::rpa_words_t         stored_i,
  output rpa_pkg::rpa_words_t         store_o,
  output rpa_pkg::rpa_words_t         result_o
);

  logic               use_q;
  logic               use_r;
  rpa_pkg::rpa_words_t old_w;
  rpa_pkg::rpa_words_t new_w;

  // Parity count decode; zero behaves as P only
  always_comb begin
    unique case (ctrl_i.count)
      rpa_pkg::PC_NONE, rpa_pkg::PC_P: begin
        use_q = 1'b0;
        use_r = 1'b0;
      end
      rpa_pkg::PC_PQ: begin
        use_q = 1'b1;
        use_r = 1'b0;
      end
      rpa_pkg::PC_PQR: begin
        use_q = 1'b1;
        use_r = 1'b1;
      end
      default: begin
        use_q = 1'b0;
        use_r = 1'b0;
      end
    endcase
  end

  // Old parity is zero on a first column or outside the column
  always_comb begin
    if (ctrl_i.first_column || !ctrl_i.in_range) begin
      old_w = '0;
    end else begin
      old_w = stored_i;
    end
  end

  // P ^= d, Q = 2Q ^ d, R = 4R ^ d
  always_comb begin
    new_w.p = old_w.p ^ data_i;
    new_w.q = rpa_pkg::gf_times2(old_w.q) ^ data_i;
    new_w.r = rpa_pkg::gf_times2(rpa_pkg::gf_times2(old_w.r)) ^ data_i;
  end

  // Unused syndromes keep their stored word and return zero
  always_comb begin
    store_o.p  = new_w.p;
    store_o.q  = use_q ? new_w.q : stored_i.q;
    store_o.r  = use_r ? new_w.r : stored_i.r;
    result_o.p = new_w.p;
    result_o.q = use_q ? new_w.q : '0;
    result_o.r = use_r ? new_w.r : '0;
  end

endmodule
